FILE: sv/cq_pkg.sv
package cq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SHOW = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_ROT
    } cmd_kind_t;

    // broadcast to every cell; count is the fill level before the update
    typedef struct packed {
        cmd_kind_t         kind;
        logic [CNT_W-1:0]  count;
    } ring_cmd_t;

endpackage

FILE: sv/cq_cell.sv
module cq_cell (
    input  logic                       aclk,
    input  cq_pkg::ring_cmd_t          cmd,
    input  logic [cq_pkg::IDX_W-1:0]   cell_idx,
    input  logic [cq_pkg::WORD_W-1:0]  push_word,
    input  logic [cq_pkg::WORD_W-1:0]  next_word,
    input  logic [cq_pkg::WORD_W-1:0]  ring_word,
    output logic [cq_pkg::WORD_W-1:0]  word
);
    import cq_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [CNT_W-1:0]  my_pos;
    logic [CNT_W-1:0]  top_pos;

    assign my_pos  = CNT_W'(cell_idx);
    assign top_pos = cmd.count - 1'b1;

    always_comb begin
        word_next = word_reg;
        case (cmd.kind)
            CMD_PUSH: begin
                if (my_pos == cmd.count) word_next = push_word;
            end
            CMD_POP: begin
                word_next = next_word;
            end
            CMD_ROT: begin
                // ring closes at the newest entry: it takes the oldest word
                word_next = (my_pos == top_pos) ? ring_word : next_word;
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

FILE: sv/cq_ctrl.sv
module cq_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 opcode,
    input  logic [cq_pkg::WORD_W-1:0]  head_word,
    output cq_pkg::ring_cmd_t          cmd,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cq_pkg::WORD_W-1:0]  m_word,
    output logic [1:0]                 m_status,
    output logic                       m_last
);
    import cq_pkg::*;

    typedef enum logic {S_IDLE, S_SHOW} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   show_idx_reg, show_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  m_word_reg, m_word_next;
    status_t            m_status_reg, m_status_next;
    logic               m_last_reg, m_last_next;
    logic               out_free;
    logic               accept;
    logic               show_last;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign show_last = (CNT_W'(show_idx_reg) == count_reg - 1'b1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        show_idx_next = show_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_word_next   = m_word_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        cmd.kind      = CMD_HOLD;
        cmd.count     = count_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (opcode)
                        OP_ENQ: begin
                            m_valid_next = 1'b1;
                            m_word_next  = '0;
                            m_last_next  = 1'b1;
                            if (count_reg == CNT_W'(DEPTH)) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                m_status_next = STAT_OK;
                                cmd.kind      = CMD_PUSH;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = STAT_EMPTY;
                                m_word_next   = '0;
                            end else begin
                                m_status_next = STAT_OK;
                                m_word_next   = head_word;
                                cmd.kind      = CMD_POP;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        OP_SHOW: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_EMPTY;
                                m_word_next   = '0;
                                m_last_next   = 1'b1;
                            end else begin
                                state_next    = S_SHOW;
                                show_idx_next = '0;
                            end
                        end
                        default: begin
                            // unknown opcode: dropped without a result
                        end
                    endcase
                end
            end
            S_SHOW: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_word_next   = head_word;
                    m_last_next   = show_last;
                    cmd.kind      = CMD_ROT;
                    show_idx_next = show_idx_reg + 1'b1;
                    if (show_last) state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_word_reg   <= m_word_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        show_idx_reg <= show_idx_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_word   = m_word_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond capacity");

    a_show_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHOW |-> CNT_W'(show_idx_reg) < count_reg)
        else $error("display walk past newest entry");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && opcode == OP_ENQ && count_reg == CNT_W'(DEPTH)
        |=> count_reg == CNT_W'(DEPTH) && m_status_reg == STAT_FULL)
        else $error("enqueue on full queue changed fill level");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && opcode == OP_DEQ && count_reg != '0
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not remove one entry");

endmodule

FILE: sv/circular_queue.sv
// Ring-buffer queue of signed 32-bit words, DEPTH entries, in a row of cells.
// Input requests arrive on s_*: s_tuser carries the opcode (enqueue, dequeue,
// display), s_tdata the word to store. Results leave on m_*: m_tuser holds the
// status (ok, full, empty), m_tdata the word, m_tlast marks the final result
// of a request.
// Enqueue and dequeue give one result, registered in the cycle after the request
// is taken; with the receiver ready a new request is taken every cycle.
// Display walks the stored entries oldest first by rotating the cell row one
// place per cycle while the output register is free; the row is back in order
// when the walk ends. An empty display or dequeue gives a single empty status.
// Opcode 3 is taken and dropped.
// A stalled receiver holds the output register; the input side takes a
// request only when that register is free or being emptied, and the display
// walk pauses while it waits.
// Reset (aresetn low, synchronous) empties the queue and clears the output
// valid; stored words are not cleared.
module circular_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] word_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import cq_pkg::*;

    ring_cmd_t          cmd;
    logic [WORD_W-1:0]  cell_word [DEPTH];
    logic [WORD_W-1:0]  cell_next [DEPTH];

    cq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .opcode    (s_tuser),
        .head_word (cell_word[0]),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_word    (m_tdata),
        .m_status  (m_tuser),
        .m_last    (m_tlast)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_end
            assign cell_next[i] = '0;
        end else begin : g_mid
            assign cell_next[i] = cell_word[i+1];
        end

        cq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .cell_idx  (IDX_W'(i)),
            .push_word (s_tdata),
            .next_word (cell_next[i]),
            .ring_word (cell_word[0]),
            .word      (cell_word[i])
        );
    end

endmodule

FILE: tb/tb_circular_queue.sv
`timescale 1ns / 1ps

module tb_circular_queue;
    import cq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 140;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] word;
        logic              last;
    } response_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // Mirrors the ring contents and queues the responses each request must produce.
    class queue_scoreboard;
        logic [WORD_W-1:0] ring [DEPTH];
        int                head_idx;
        int                tail_idx;
        bit                empty;
        response_t         due_responses [$];
        int                errors;
        int                checked;

        function new();
            head_idx = 0;
            tail_idx = 0;
            empty    = 1'b1;
            errors   = 0;
            checked  = 0;
        endfunction

        function void add_response(status_t st, logic [WORD_W-1:0] word, logic last);
            response_t r;
            r.status = st;
            r.word   = word;
            r.last   = last;
            due_responses.push_back(r);
        endfunction

        function void note_request(op_t op, logic [WORD_W-1:0] value);
            int idx;
            bit done;
            case (op)
                OP_ENQ: begin
                    if (empty) begin
                        head_idx = 0;
                        tail_idx = 0;
                        ring[0]  = value;
                        empty    = 1'b0;
                        add_response(STAT_OK, '0, 1'b1);
                    end else if ((tail_idx + 1) % DEPTH == head_idx) begin
                        add_response(STAT_FULL, '0, 1'b1);
                    end else begin
                        tail_idx       = (tail_idx + 1) % DEPTH;
                        ring[tail_idx] = value;
                        add_response(STAT_OK, '0, 1'b1);
                    end
                end
                OP_DEQ: begin
                    if (empty) begin
                        add_response(STAT_EMPTY, '0, 1'b1);
                    end else begin
                        add_response(STAT_OK, ring[head_idx], 1'b1);
                        if (head_idx == tail_idx) begin
                            head_idx = 0;
                            tail_idx = 0;
                            empty    = 1'b1;
                        end else begin
                            head_idx = (head_idx + 1) % DEPTH;
                        end
                    end
                end
                OP_SHOW: begin
                    if (empty) begin
                        add_response(STAT_EMPTY, '0, 1'b1);
                    end else begin
                        idx  = head_idx;
                        done = 1'b0;
                        while (!done) begin
                            done = (idx == tail_idx);
                            add_response(STAT_OK, ring[idx], done);
                            idx = (idx + 1) % DEPTH;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(status_t st, logic [WORD_W-1:0] word, logic last);
            response_t exp;
            if (due_responses.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected response status=%0d word=%h last=%0b",
                             st, word, last);
                return;
            end
            exp = due_responses.pop_front();
            checked++;
            if (exp.status !== st || exp.word !== word || exp.last !== last) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: response %0d exp status=%0d word=%h last=%0b",
                             checked, exp.status, exp.word, exp.last);
                    $display("       got status=%0d word=%h last=%0b", st, word, last);
                end
            end
        endfunction

        function int pending();
            return due_responses.size();
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    queue_scoreboard board;
    int              cycles = 0;
    int              n_enq = 0, n_deq = 0, n_show = 0, n_none = 0;
    int              ready_mode = 0;
    int              ready_phase = 0;

    circular_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached with %0d responses outstanding",
                     board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: check accepted responses, then pick next ready from a mode that is
    // redrawn at random each time ready_phase wraps.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(status_t'(m_tuser), m_tdata, m_tlast);
        if (ready_phase == 49) begin
            ready_phase <= 0;
            ready_mode  <= $urandom_range(0, 3);
        end else begin
            ready_phase <= ready_phase + 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ((ready_phase % 7) < 4);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_request(input op_t op, input logic [WORD_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_request(op, value);
        case (op)
            OP_ENQ:  n_enq++;
            OP_DEQ:  n_deq++;
            OP_SHOW: n_show++;
            default: n_none++;
        endcase
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // hold off the sender until every outstanding response has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);
    endtask

    function automatic op_t pick_op(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OP_NONE;
        case (mix)
            MIX_FILL:  return (r < 75) ? OP_ENQ : (r < 88) ? OP_DEQ : OP_SHOW;
            MIX_DRAIN: return (r < 22) ? OP_ENQ : (r < 85) ? OP_DEQ : OP_SHOW;
            default:   return (r < 45) ? OP_ENQ : (r < 80) ? OP_DEQ : OP_SHOW;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random requests in bursts; op 3 requests do not count toward n
    task automatic run_mix(input mix_t mix, input int n);
        int   done_reqs;
        int   burst;
        op_t  op;
        done_reqs = 0;
        while (done_reqs < n) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && done_reqs < n) begin
                op = pick_op(mix);
                send_request(op, pick_word());
                if (op != OP_NONE)
                    done_reqs++;
                burst--;
            end
            if ($urandom_range(0, 9) >= 3)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue: display, dequeue, then an ignored opcode
        send_request(OP_SHOW, 32'h0);
        send_request(OP_DEQ, 32'h1234_5678);
        send_request(OP_NONE, 32'hFFFF_FFFF);
        // fill with extreme words, then one more while full
        send_request(OP_ENQ, 32'h8000_0000);
        send_request(OP_ENQ, 32'h7FFF_FFFF);
        send_request(OP_ENQ, 32'h0000_0000);
        send_request(OP_ENQ, 32'hFFFF_FFFF);
        send_request(OP_ENQ, 32'hAAAA_AAAA);
        send_request(OP_ENQ, 32'h5555_5555);
        send_request(OP_ENQ, 32'h0000_0001);
        send_request(OP_ENQ, 32'hFFFF_FFFE);
        send_request(OP_ENQ, 32'h1357_9BDF);
        send_request(OP_SHOW, 32'h0);
        // wrap the tail past the end of the ring
        repeat (2) send_request(OP_DEQ, 32'h0);
        send_request(OP_ENQ, 32'hDEAD_BEEF);
        send_request(OP_ENQ, 32'h0F0F_F0F0);
        send_request(OP_SHOW, 32'h0);
        repeat (8) send_request(OP_DEQ, 32'h0);
        send_request(OP_DEQ, 32'h0);
        // single entry after emptying
        send_request(OP_ENQ, 32'h2468_ACE0);
        send_request(OP_SHOW, 32'h0);
        wait_drained();

        run_mix(MIX_FILL, 40);
        run_mix(MIX_EVEN, 35);
        wait_drained();
        run_mix(MIX_DRAIN, 30);
        run_mix(MIX_FILL, 30);
        run_mix(MIX_EVEN, RANDOM_REQS - 135);

        wait_drained();
        repeat (4 * DEPTH) @(posedge aclk);

        $display("Covered %0d enqueue, %0d dequeue, %0d display and %0d ignored requests;",
                 n_enq, n_deq, n_show, n_none);
        $display("%0d responses compared, %0d mismatches, %0d still outstanding.",
                 board.checked, board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
